@@ hw/rtl/iqpu_pkg.sv @@
// ----------------------------------------------------------------------------
// iqpu_pkg: shared types and constants for the I/Q phase unwrapper
// Sample widths, CORDIC sizing, the arctangent table and the beat type that
// moves from one CORDIC cell to the next.
// ----------------------------------------------------------------------------
package iqpu_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  localparam int FIELD_W  = 16;  // width of the sample ports
  localparam int FRAC_BITS = 8;  // samples are scaled by 2^8 before rotating
  // scaled magnitude grows by at most sqrt(2) * 1.647 < 4, plus a sign bit
  localparam int DATA_W   = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int IDX_W    = 5;   // enough to index MAX_STAGES entries
  localparam int ACC_W    = 32;  // 2^32 units per turn in the angle accumulator
  localparam int ANGLE_W  = 16;  // 2^16 units per turn in the wrapped angle
  localparam int PHASE_W  = 32;  // running unwrapped total

  localparam logic [ACC_W-1:0] HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ROUND_BIT = ACC_W'(1) << (ACC_W - ANGLE_W - 1);

  typedef logic signed [DATA_W-1:0] data_t;

  // payload carried through the CORDIC chain
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [ACC_W-1:0]  acc;
    logic              zero;   // input vector was exactly zero
    logic              start;  // first sample of a block
  } cordic_beat_t;

  // atan(2^-s) in 2^32 units per turn, rounded to nearest
  function automatic logic [ACC_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/iqpu_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// iqpu_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates the incoming vector toward the x axis by atan(2^-s) and registers
// the result; holds its beat while the next cell stalls.
// ----------------------------------------------------------------------------
module iqpu_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [iqpu_pkg::IDX_W-1:0]   stage_idx,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  iqpu_pkg::cordic_beat_t       up_beat,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output iqpu_pkg::cordic_beat_t       dn_beat
);

  logic                   valid_r;
  iqpu_pkg::cordic_beat_t beat_r;
  iqpu_pkg::cordic_beat_t beat_nxt;
  iqpu_pkg::data_t        x_in;
  iqpu_pkg::data_t        y_in;
  iqpu_pkg::data_t        x_sh;
  iqpu_pkg::data_t        y_sh;
  logic [iqpu_pkg::ACC_W-1:0] angle_step;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

  always_comb begin
    x_in       = iqpu_pkg::data_t'(up_beat.x);
    y_in       = iqpu_pkg::data_t'(up_beat.y);
    x_sh       = x_in >>> stage_idx;
    y_sh       = y_in >>> stage_idx;
    angle_step = iqpu_pkg::atan_lut(stage_idx);
    beat_nxt   = up_beat;
    if (!y_in[iqpu_pkg::DATA_W-1]) begin
      beat_nxt.x   = x_in + y_sh;
      beat_nxt.y   = y_in - x_sh;
      beat_nxt.acc = up_beat.acc + angle_step;
    end else begin
      beat_nxt.x   = x_in - y_sh;
      beat_nxt.y   = y_in + x_sh;
      beat_nxt.acc = up_beat.acc - angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

@@ hw/rtl/iqpu_unwrap.sv @@
// ----------------------------------------------------------------------------
// iqpu_unwrap: angle rounding, phase unwrap and output register
// Rounds the CORDIC accumulator to a 16-bit angle, loads it on a block start
// or adds the wrapped difference to the saturating running total; outputs it.
// ----------------------------------------------------------------------------
module iqpu_unwrap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  iqpu_pkg::cordic_beat_t        up_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iqpu_pkg::PHASE_W-1:0]  out_phase
);

  logic                           valid_r;
  logic [iqpu_pkg::PHASE_W-1:0]   total_r;
  logic [iqpu_pkg::PHASE_W-1:0]   total_nxt;
  logic [iqpu_pkg::ANGLE_W-1:0]   last_r;
  logic                           start_r;
  logic                           zero_r;
  logic [iqpu_pkg::ACC_W-1:0]     rounded;
  logic [iqpu_pkg::ANGLE_W-1:0]   angle;
  logic [iqpu_pkg::ANGLE_W-1:0]   diff;
  logic [iqpu_pkg::PHASE_W:0]     sum;
  logic                           load;

  assign up_ready  = !valid_r || out_ready;
  assign load      = up_valid && up_ready;
  assign out_valid = valid_r;
  assign out_phase = total_r;

  always_comb begin
    rounded = up_beat.acc + iqpu_pkg::ROUND_BIT;
    angle   = up_beat.zero ? '0 : rounded[iqpu_pkg::ACC_W-1 -: iqpu_pkg::ANGLE_W];
    // a half-turn difference wraps to the negative end by construction
    diff    = angle - last_r;
    sum     = {total_r[iqpu_pkg::PHASE_W-1], total_r}
            + {{(iqpu_pkg::PHASE_W-iqpu_pkg::ANGLE_W+1){diff[iqpu_pkg::ANGLE_W-1]}}, diff};
    if (up_beat.start) begin
      total_nxt = {{(iqpu_pkg::PHASE_W-iqpu_pkg::ANGLE_W){angle[iqpu_pkg::ANGLE_W-1]}}, angle};
    end else if (sum[iqpu_pkg::PHASE_W] != sum[iqpu_pkg::PHASE_W-1]) begin
      // clamp on overflow toward the sign of the true sum
      total_nxt = {sum[iqpu_pkg::PHASE_W], {(iqpu_pkg::PHASE_W-1){!sum[iqpu_pkg::PHASE_W]}}};
    end else begin
      total_nxt = sum[iqpu_pkg::PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= '0;
      last_r  <= '0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (load) begin
        total_r <= total_nxt;
        last_r  <= angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= up_beat.start;
      zero_r  <= up_beat.zero;
    end
  end

  // a block start loads a sign-extended 16-bit angle
  a_start_fits: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && start_r |->
      total_r[iqpu_pkg::PHASE_W-1:iqpu_pkg::ANGLE_W-1] == '0 ||
      total_r[iqpu_pkg::PHASE_W-1:iqpu_pkg::ANGLE_W-1] == '1)
    else $error("block start total is not a sign-extended angle");

  // a zero vector at block start restarts the total at zero
  a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && start_r && zero_r |-> total_r == '0)
    else $error("zero vector at block start gave a nonzero total");

  // the saved angle always matches the low half of a freshly loaded start total
  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && start_r |-> last_r == total_r[iqpu_pkg::ANGLE_W-1:0])
    else $error("saved angle disagrees with block start total");

endmodule

@@ hw/rtl/iq_phase_unwrap_core.sv @@
// ----------------------------------------------------------------------------
// iq_phase_unwrap_core: CORDIC angle and unwrapped phase of an I/Q stream
// A chain of CORDIC vectoring cells finds the angle of each sample; a final
// stage turns it into a saturating 32-bit unwrapped phase.
// ----------------------------------------------------------------------------
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_i_sample,           | sink
//          | in_q_sample, in_block_start                |
//  out     | out_valid, out_ready, out_unwrapped_phase  | source
//
// Throughput: one beat per clock unless out_ready holds the chain; every cell
//   and the unwrap stage accept a new beat in the cycle they hand theirs on.
// Pipeline: 16 CORDIC cells plus the unwrap/output register.
// Stalls: each cell holds its beat while the next one is full and stalled;
//   empty cells keep filling, so bubbles close up behind a stalled output.
// Reset: synchronous, active low; clears all valid bits, the running total
//   and the saved angle.
// ----------------------------------------------------------------------------
module iq_phase_unwrap_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [iqpu_pkg::FIELD_W-1:0] in_i_sample,
  input  logic signed [iqpu_pkg::FIELD_W-1:0] in_q_sample,
  input  logic                          in_block_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [iqpu_pkg::PHASE_W-1:0] out_unwrapped_phase
);

  localparam int NS = iqpu_pkg::NUM_STAGES;
  localparam int SB = iqpu_pkg::SAMPLE_BITS;
  localparam int DW = iqpu_pkg::DATA_W;

  // link k feeds cell k; link NS feeds the unwrap stage
  iqpu_pkg::cordic_beat_t   link_beat  [0:NS];
  logic                     link_valid [0:NS];
  logic                     link_ready [0:NS];

  iqpu_pkg::cordic_beat_t   head_beat;
  logic [SB-1:0]            i_bits;
  logic [SB-1:0]            q_bits;
  logic [DW-1:0]            x_scaled;
  logic [DW-1:0]            y_scaled;
  logic [iqpu_pkg::PHASE_W-1:0] phase;

  // Prescale: sign-extend, scale by 2^8, fold the left half-plane over.
  always_comb begin
    i_bits   = in_i_sample[SB-1:0];
    q_bits   = in_q_sample[SB-1:0];
    x_scaled = {{(DW-SB){i_bits[SB-1]}}, i_bits} << iqpu_pkg::FRAC_BITS;
    y_scaled = {{(DW-SB){q_bits[SB-1]}}, q_bits} << iqpu_pkg::FRAC_BITS;
    head_beat.zero  = (i_bits == '0) && (q_bits == '0);
    head_beat.start = in_block_start;
    if (x_scaled[DW-1]) begin
      head_beat.x   = -x_scaled;
      head_beat.y   = -y_scaled;
      head_beat.acc = iqpu_pkg::HALF_TURN;
    end else begin
      head_beat.x   = x_scaled;
      head_beat.y   = y_scaled;
      head_beat.acc = '0;
    end
  end

  assign link_beat[0]  = head_beat;
  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];

  // Chain of rotation cells, one micro-rotation each.
  for (genvar k = 0; k < NS; k++) begin : g_cell
    iqpu_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (iqpu_pkg::IDX_W'(k)),
      .up_valid  (link_valid[k]),
      .up_ready  (link_ready[k]),
      .up_beat   (link_beat[k]),
      .dn_valid  (link_valid[k+1]),
      .dn_ready  (link_ready[k+1]),
      .dn_beat   (link_beat[k+1])
    );
  end

  // Round, unwrap, accumulate and hold the result beat.
  iqpu_unwrap u_unwrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (link_valid[NS]),
    .up_ready  (link_ready[NS]),
    .up_beat   (link_beat[NS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_phase (phase)
  );

  assign out_unwrapped_phase = phase;

  // an empty first cell never refuses a beat
  a_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    !g_cell[0].u_cell.dn_valid |-> in_ready)
    else $error("input stalled with an empty first cell");

  // an empty output register never backs up the chain
  a_tail_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> link_ready[NS])
    else $error("chain stalled with an empty output register");

  // an accepted beat reaches the first cell on the next edge
  a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> link_valid[1])
    else $error("accepted beat did not enter the first cell");

endmodule

@@ sim/iq_phase_unwrap_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iq_phase_unwrap_core_tb: self-checking bench for the I/Q phase unwrapper
// Streams I/Q beats into the core through a gap-inserting driver and drains
// the unwrapped phase through a stalling monitor. A bit-exact CORDIC and
// unwrap predictor runs on every accepted input beat, and each output beat
// is compared against the oldest predicted phase. Compass spins walk the
// running total steadily up and down across many turns.
// ----------------------------------------------------------------------------
module iq_phase_unwrap_core_tb;

  localparam int FIELD_W    = iqpu_pkg::FIELD_W;
  localparam int PHASE_W    = iqpu_pkg::PHASE_W;
  localparam int ACC_W      = iqpu_pkg::ACC_W;
  localparam int ANGLE_W    = iqpu_pkg::ANGLE_W;
  localparam int FRAC_BITS  = iqpu_pkg::FRAC_BITS;
  localparam int MAX_STAGES = iqpu_pkg::MAX_STAGES;
  localparam int NUM_STAGES = iqpu_pkg::NUM_STAGES;
  localparam logic [ACC_W-1:0] HALF_TURN = iqpu_pkg::HALF_TURN;
  localparam logic [ACC_W-1:0] ROUND_BIT = iqpu_pkg::ROUND_BIT;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int SPIN_LEN    = 32;      // beats of +/-3/8 turn per spin
  localparam int HOLD_AT     = 60;      // input beat count that starts the long hold
  localparam int HOLD_CYC    = 120;     // cycles the receiver holds off

  localparam logic signed [PHASE_W-1:0] PHASE_MAX = {1'b0, {(PHASE_W-1){1'b1}}};
  localparam logic signed [PHASE_W-1:0] PHASE_MIN = {1'b1, {(PHASE_W-1){1'b0}}};

  // One pending input beat plus the idle pattern to apply around it
  typedef struct {
    logic signed [FIELD_W-1:0] i_val;
    logic signed [FIELD_W-1:0] q_val;
    logic                      blk;
    int                        gap_after;
    bit                        rx_idle;
  } iq_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [FIELD_W-1:0]   in_i_sample = '0;
  logic signed [FIELD_W-1:0]   in_q_sample = '0;
  logic                        in_block_start = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [PHASE_W-1:0]   out_unwrapped_phase;

  // atan(2^-s) in 2^32 units per turn, rounded to nearest
  logic [ACC_W-1:0] atan_turns [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  iq_beat_t                  pending[$];
  logic signed [PHASE_W-1:0] phase_expect[$];

  // predictor state, touched only by the driver
  logic [ANGLE_W-1:0]        last_angle = '0;
  logic signed [PHASE_W-1:0] phase_sum = '0;

  int  in_beats = 0;
  int  out_beats = 0;
  int  errors = 0;
  int  sat_hits = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  rx_idle_on = 1'b1;
  bit  saw_full_stall = 1'b0;

  iq_phase_unwrap_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_i_sample         (in_i_sample),
    .in_q_sample         (in_q_sample),
    .in_block_start      (in_block_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_unwrapped_phase (out_unwrapped_phase)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Vectoring CORDIC: rotate the vector onto the +x axis and accumulate the
  // rotation angle. Left half-plane vectors are folded over first and start
  // from half a turn. Shifts floor toward minus infinity.
  function automatic logic [ANGLE_W-1:0] vector_angle(
    logic signed [FIELD_W-1:0] i_s,
    logic signed [FIELD_W-1:0] q_s
  );
    longint           x;
    longint           y;
    longint           xs;
    longint           ys;
    logic [ACC_W-1:0] acc;
    if (i_s == 0 && q_s == 0) return '0;
    x   = longint'(i_s) * (longint'(1) << FRAC_BITS);
    y   = longint'(q_s) * (longint'(1) << FRAC_BITS);
    acc = '0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = HALF_TURN;
    end
    for (int s = 0; s < NUM_STAGES; s++) begin
      xs = x >>> s;
      ys = y >>> s;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + atan_turns[s];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - atan_turns[s];
      end
    end
    acc = acc + ROUND_BIT;
    return acc[ACC_W-1 -: ANGLE_W];
  endfunction

  // Work out the phase the core must return for one accepted input beat
  task automatic predict_phase(
    logic signed [FIELD_W-1:0] i_s,
    logic signed [FIELD_W-1:0] q_s,
    logic                      blk
  );
    logic [ANGLE_W-1:0]        ang;
    logic signed [ANGLE_W-1:0] step;
    longint                    sum;
    ang = vector_angle(i_s, q_s);
    if (blk) begin
      phase_sum = PHASE_W'($signed(ang));
    end else begin
      // wrapped difference; exactly half a turn reads as negative
      step = $signed(ang - last_angle);
      sum  = longint'(phase_sum) + longint'(step);
      if (sum > longint'(PHASE_MAX)) begin
        sum = longint'(PHASE_MAX);
        sat_hits++;
      end else if (sum < longint'(PHASE_MIN)) begin
        sum = longint'(PHASE_MIN);
        sat_hits++;
      end
      phase_sum = PHASE_W'(sum);
    end
    last_angle = ang;
    phase_expect.push_back(phase_sum);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // At least half the draws give no wait so back-to-back beats stay common
  function automatic int draw_wait(bit idle_on);
    if (!idle_on) return 0;
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic queue_beat(int i_v, int q_v, bit blk, bit idle_on);
    iq_beat_t b;
    b.i_val     = FIELD_W'(i_v);
    b.q_val     = FIELD_W'(q_v);
    b.blk       = blk;
    b.gap_after = draw_wait(idle_on);
    b.rx_idle   = idle_on;
    pending.push_back(b);
  endtask

  // Vector of amplitude amp on one of eight compass points, counterclockwise
  // from +I in steps of 1/8 turn
  task automatic queue_compass(int point, int amp, bit blk, bit idle_on);
    int i_v;
    int q_v;
    case (point)
      0:       begin i_v =  amp; q_v =    0; end
      1:       begin i_v =  amp; q_v =  amp; end
      2:       begin i_v =    0; q_v =  amp; end
      3:       begin i_v = -amp; q_v =  amp; end
      4:       begin i_v = -amp; q_v =    0; end
      5:       begin i_v = -amp; q_v = -amp; end
      6:       begin i_v =    0; q_v = -amp; end
      default: begin i_v =  amp; q_v = -amp; end
    endcase
    queue_beat(i_v, q_v, blk, idle_on);
  endtask

  // Spin by 3/8 turn per beat, with no idling, to walk the total across
  // many turns. The first beat of the spin opens a new block.
  task automatic queue_spin(int dir, int beats);
    int point;
    point = 0;
    for (int n = 0; n < beats; n++) begin
      point = (point + 8 + 3 * dir) % 8;
      queue_compass(point, $urandom_range(4000, 32767), n == 0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer pending beats, hold each one until it is taken, then idle
  // for the gap drawn for it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_driver
    iq_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_phase(in_i_sample, in_q_sample, in_block_start);
        in_beats <= in_beats + 1;
      end
      if (in_valid && !in_ready && out_valid && !out_ready)
        saw_full_stall <= 1'b1;
      // the slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt            = pending.pop_front();
          in_valid       <= 1'b1;
          in_i_sample    <= nxt.i_val;
          in_q_sample    <= nxt.q_val;
          in_block_start <= nxt.blk;
          gap_left       <= nxt.gap_after;
          rx_idle_on     <= nxt.rx_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold: once the sender is streaming, drop out_ready for a
  // long stretch so the whole cell chain fills and in_ready falls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_hold
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_beats >= HOLD_AT) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take result beats, compare with the oldest prediction, then
  // stall for a freshly drawn number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : phase_monitor
    int                        stall;
    logic signed [PHASE_W-1:0] want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      stall = stall_left;
      if (out_valid && out_ready) begin
        out_beats++;
        if (phase_expect.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] ERROR: unexpected result beat, phase=%0d",
                     $realtime, out_unwrapped_phase);
        end else begin
          want = phase_expect.pop_front();
          if (out_unwrapped_phase !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("[%0t] ERROR: result %0d phase expected %0d got %0d",
                       $realtime, out_beats, want, out_unwrapped_phase);
          end
        end
        stall = draw_wait(rx_idle_on);
      end
      stall_left <= (stall > 0) ? stall - 1 : 0;
      out_ready  <= (stall == 0) && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d predictions outstanding",
               cycles, phase_expect.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : main_seq
    bit  idle_on;
    bit  blk;
    int  pick;
    int  point;
    int  corner [5];
    corner = '{-32768, -1, 0, 1, 32767};

    // Directed: unwrap straight out of reset against a zero previous angle,
    // zero vector, half-turn steps both ways, every quadrant corner and the
    // negative real axis approached from both sides
    queue_beat(1000, 0, 1'b0, 1'b1);
    queue_beat(0, 0, 1'b0, 1'b1);
    queue_beat(-32768, 0, 1'b0, 1'b1);
    queue_beat(0, 0, 1'b0, 1'b1);
    queue_beat(32767, 32767, 1'b1, 1'b1);
    queue_beat(-32768, -32768, 1'b0, 1'b1);
    queue_beat(32767, -32768, 1'b0, 1'b1);
    queue_beat(-32768, 32767, 1'b0, 1'b1);
    queue_beat(0, 32767, 1'b0, 1'b1);
    queue_beat(0, -32768, 1'b0, 1'b1);
    queue_beat(-1, 0, 1'b0, 1'b1);
    queue_beat(0, -1, 1'b0, 1'b1);
    queue_beat(-1, -1, 1'b0, 1'b1);
    queue_beat(1, 1, 1'b0, 1'b1);
    queue_beat(-32768, 1, 1'b0, 1'b1);
    queue_beat(-32768, -1, 1'b0, 1'b1);
    queue_beat(-32768, 1, 1'b0, 1'b1);
    queue_beat(32767, 0, 1'b0, 1'b1);
    queue_beat(0, 0, 1'b1, 1'b1);
    queue_beat(0, 0, 1'b1, 1'b1);
    queue_beat(-32767, -32768, 1'b0, 1'b1);

    // Spins: wind the total up over several turns, ease back, then restart
    // a block and wind it down
    queue_spin(1, SPIN_LEN);
    for (int n = 0; n < 20; n++)
      queue_compass((8 - 3 * (n + 1) % 8) % 8, 20000, 1'b0, 1'b0);
    queue_spin(-1, SPIN_LEN);
    for (int n = 0; n < 20; n++)
      queue_compass((3 * (n + 1)) % 8, 20000, 1'b0, 1'b0);

    // Random: segments that idle or stream; half arbitrary samples, mixed
    // with compass points, field corners and slow rotations
    point = 0;
    for (int seg = 0; seg < 32; seg++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 7);
        blk  = ($urandom_range(0, 19) == 0);
        if (pick < 4) begin
          queue_beat($urandom, $urandom, blk, idle_on);
        end else if (pick < 6) begin
          queue_compass($urandom_range(0, 7), $urandom_range(1, 32767), blk, idle_on);
        end else if (pick == 6) begin
          queue_beat(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
                     blk, idle_on);
        end else begin
          point = (point + 1) % 8;
          queue_compass(point, $urandom_range(1, 32767), blk, idle_on);
        end
      end
    end

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every beat offered and taken, every prediction matched
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (phase_expect.size() != 0) @(posedge clk);
    // give any stray beat time to fall out of the pipeline
    repeat (NUM_STAGES + 8) @(posedge clk);

    $display("Run covered %0d input beats and %0d phase results, %0d on a saturation rail.",
             in_beats, out_beats, sat_hits);
    $display("Input back-pressure from a full pipeline seen: %s, errors: %0d",
             saw_full_stall ? "yes" : "no", errors);
    if (errors == 0 && phase_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
